FILE: rtl/core/tptr_pkg.sv
// tptr_pkg: shared types, register codes, parse offsets and reset values
// for the TCP port tag rewriter. No dependencies; every other file uses it.

package tptr_pkg;

   // Widths fixed by the frame format and the register map
   localparam int BYTE_W    = 8;
   localparam int PORT_W    = 16;
   localparam int TAG_W     = 4;
   localparam int VERDICT_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int OFF_W     = 7;

   // Default depth of the delay line and of the overflow queue
   localparam int HOLD_DEFAULT  = 20;
   localparam int QUEUE_DEFAULT = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_POP     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_TAG     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVICE_PORT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TUNNEL_PORT  = 2'd3;

   // Register reset values
   localparam logic              MODE_POP_RST     = 1'b0;
   localparam logic [TAG_W-1:0]  FLOW_TAG_RST     = 4'h1;
   localparam logic [PORT_W-1:0] SERVICE_PORT_RST = 16'd8080;
   localparam logic [PORT_W-1:0] TUNNEL_PORT_RST  = 16'd80;

   // Verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_PASS    = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_REWRITE = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_DROP    = 2'd2;

   // Action decided ahead of the end of the TCP header
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_REWRITE = 2'd1;
   localparam logic [1:0] ACT_DROP    = 2'd2;

   // Frame offsets and header values
   localparam logic [OFF_W-1:0]  OFF_ETYPE_LO  = 7'd13;
   localparam logic [OFF_W-1:0]  OFF_IHL       = 7'd14;
   localparam logic [OFF_W-1:0]  OFF_PROTO     = 7'd23;
   localparam logic [OFF_W-1:0]  ETH_HDR_LEN   = 7'd14;
   localparam logic [BYTE_W-1:0] ETYPE_IPV4_HI = 8'h08;
   localparam logic [BYTE_W-1:0] ETYPE_IPV4_LO = 8'h00;
   localparam logic [3:0]        IHL_MIN       = 4'd5;
   localparam logic [BYTE_W-1:0] PROTO_TCP     = 8'd6;

   // Offsets within the TCP header
   localparam logic [OFF_W-1:0] REL_PORT_HI = 7'd2;
   localparam logic [OFF_W-1:0] REL_PORT_LO = 7'd3;
   localparam logic [OFF_W-1:0] REL_W12_HI  = 7'd12;
   localparam logic [OFF_W-1:0] REL_W12_LO  = 7'd13;
   localparam logic [OFF_W-1:0] REL_PREP    = 7'd14;
   localparam logic [OFF_W-1:0] REL_FOLD    = 7'd15;
   localparam logic [OFF_W-1:0] REL_CSUM_HI = 7'd16;
   localparam logic [OFF_W-1:0] REL_CSUM_LO = 7'd17;
   localparam logic [OFF_W-1:0] REL_CSUM_AD = 7'd18;
   localparam logic [OFF_W-1:0] REL_LAST    = 7'd19;
   localparam int               TCP_LAST    = 19;

   typedef struct packed {
      logic              mode_pop;
      logic [TAG_W-1:0]  flow_tag;
      logic [PORT_W-1:0] service_port;
      logic [PORT_W-1:0] tunnel_port;
   } cfg_type;

   typedef struct packed {
      logic eth_ip;
      logic ihl_ok;
      logic tcp;
      logic rewrote;
      logic drop;
   } flags_type;

   typedef struct packed {
      logic drain_busy;
      logic queue_full;
   } stat_type;

   typedef struct packed {
      logic              push;
      logic [BYTE_W-1:0] data;
   } push_type;

   typedef struct packed {
      logic              avail;
      logic [BYTE_W-1:0] data;
   } qhead_type;

   typedef struct packed {
      logic                 load;
      logic [VERDICT_W-1:0] verdict;
   } flush_type;

endpackage

FILE: rtl/core/tptr_ifs.sv
// tptr_ifs: valid/ready channel interfaces for frame words in, rewritten
// words out and register writes. Depends on tptr_pkg for widths.

interface tptr_req_if;
   logic                        valid;
   logic                        ready;
   logic [tptr_pkg::BYTE_W-1:0] in_byte;
   logic                        in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface tptr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tptr_pkg::BYTE_W-1:0]    out_byte;
   logic                           out_last;
   logic [tptr_pkg::VERDICT_W-1:0] verdict;
   modport source (output valid, output out_byte, output out_last, output verdict,
                   input ready);
   modport sink (input valid, input out_byte, input out_last, input verdict,
                 output ready);
endinterface

interface tptr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tptr_pkg::CSR_IDX_W-1:0] reg_index;
   logic [tptr_pkg::CSR_DAT_W-1:0] wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/core/tptr_front.sv
// tptr_front: accepts frame words, parses the headers, keeps the delay line
// and patches it. Depends on tptr_pkg and tptr_ifs.

module tptr_front #(
   parameter int HOLD = tptr_pkg::HOLD_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tptr_pkg::cfg_type                     cfg,
   input  tptr_pkg::stat_type                    stat,
   tptr_req_if.sink                              req,
   output tptr_pkg::push_type                    qpush,
   output tptr_pkg::flush_type                   flush,
   output logic [HOLD-1:0][tptr_pkg::BYTE_W-1:0] flush_bytes,
   output logic [$clog2(HOLD+1)-1:0]             flush_cnt
);

   localparam int CW      = $clog2(HOLD + 1);
   localparam int PORT_HI = HOLD - 1 - (tptr_pkg::TCP_LAST - 2);
   localparam int PORT_LO = HOLD - 1 - (tptr_pkg::TCP_LAST - 3);
   localparam int W12_HI  = HOLD - 1 - (tptr_pkg::TCP_LAST - 12);
   localparam int W12_LO  = HOLD - 1 - (tptr_pkg::TCP_LAST - 13);
   localparam int CSUM_HI = HOLD - 1 - (tptr_pkg::TCP_LAST - 16);
   localparam int CSUM_LO = HOLD - 1 - (tptr_pkg::TCP_LAST - 17);

   logic [HOLD-1:0][7:0] line_ff, line_in, shifted, patched;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [6:0]           off_ff, off_in, rel, tcp_base_ff, tcp_base_in;
   tptr_pkg::flags_type  flags_ff, flags_in, flags_next;
   logic [15:0]          port_ff, port_in, w12_ff, w12_in, csum_ff, csum_in;
   logic [15:0]          new_port_ff, new_port_in, new_w12_ff, new_w12_in;
   logic [15:0]          np, nw, f2;
   logic [1:0]           act_ff, act_in, act;
   logic [16:0]          s_port_ff, s_port_in, s_w12_ff, s_w12_in;
   logic [16:0]          delta_ff, delta_in, f1;
   logic [17:0]          csum_sum_ff, csum_sum_in, sum18;
   logic                 line_full, accept, at_decide, do_rewrite, do_drop;

   always_comb begin
      line_full = (cnt_ff == CW'(HOLD));
      req.ready = !((line_full && (stat.queue_full || stat.drain_busy)) ||
                    (req.in_last && stat.drain_busy));
      accept    = req.valid && req.ready;
      rel       = off_ff - tcp_base_ff;

      // action and replacement words, from the captured port and word 12
      np  = cfg.tunnel_port;
      nw  = {w12_ff[15:12], cfg.flow_tag, w12_ff[7:0]};
      act = (port_ff == cfg.service_port) ? tptr_pkg::ACT_REWRITE : tptr_pkg::ACT_NONE;
      if (cfg.mode_pop) begin
         np = cfg.service_port;
         nw = w12_ff;
         if (port_ff != cfg.tunnel_port || w12_ff[11:8] == 4'd0) begin
            act = tptr_pkg::ACT_NONE;
         end else if (w12_ff[11:8] != cfg.flow_tag) begin
            act = tptr_pkg::ACT_DROP;
         end else begin
            act = tptr_pkg::ACT_REWRITE;
         end
      end

      sum18 = 18'(s_port_ff) + 18'(s_w12_ff);
      f1    = 17'(csum_sum_ff[15:0]) + 17'(csum_sum_ff[17:16]);
      f2    = f1[15:0] + 16'(f1[16]);

      at_decide  = flags_ff.tcp && (rel == tptr_pkg::REL_LAST);
      do_rewrite = at_decide && (act_ff == tptr_pkg::ACT_REWRITE);
      do_drop    = at_decide && (act_ff == tptr_pkg::ACT_DROP);

      // shift the line down, newest word on top, then patch the TCP header
      shifted = {req.in_byte, line_ff[HOLD-1:1]};
      patched = shifted;
      if (do_rewrite) begin
         patched[PORT_HI] = new_port_ff[15:8];
         patched[PORT_LO] = new_port_ff[7:0];
         patched[W12_HI]  = new_w12_ff[15:8];
         patched[W12_LO]  = new_w12_ff[7:0];
         patched[CSUM_HI] = ~f2[15:8];
         patched[CSUM_LO] = ~f2[7:0];
      end

      flags_next = flags_ff;
      if (off_ff == tptr_pkg::OFF_ETYPE_LO && line_ff[HOLD-1] == tptr_pkg::ETYPE_IPV4_HI &&
          req.in_byte == tptr_pkg::ETYPE_IPV4_LO) begin
         flags_next.eth_ip = 1'b1;
      end
      if (off_ff == tptr_pkg::OFF_IHL && flags_ff.eth_ip &&
          req.in_byte[3:0] >= tptr_pkg::IHL_MIN) begin
         flags_next.ihl_ok = 1'b1;
      end
      if (off_ff == tptr_pkg::OFF_PROTO && flags_ff.ihl_ok &&
          req.in_byte == tptr_pkg::PROTO_TCP) begin
         flags_next.tcp = 1'b1;
      end
      flags_next.rewrote = flags_ff.rewrote || do_rewrite;
      flags_next.drop    = flags_ff.drop || do_drop;

      flush.load    = accept && req.in_last;
      flush.verdict = flags_next.drop    ? tptr_pkg::VERDICT_DROP :
                      flags_next.rewrote ? tptr_pkg::VERDICT_REWRITE :
                                           tptr_pkg::VERDICT_PASS;
      flush_bytes   = patched;
      flush_cnt     = line_full ? CW'(HOLD) : cnt_ff + 1'b1;

      qpush.push = accept && line_full;
      qpush.data = line_ff[0];

      // next state
      line_in     = line_ff;
      cnt_in      = cnt_ff;
      off_in      = off_ff;
      flags_in    = flags_ff;
      tcp_base_in = tcp_base_ff;
      port_in     = port_ff;
      w12_in      = w12_ff;
      csum_in     = csum_ff;
      new_port_in = new_port_ff;
      new_w12_in  = new_w12_ff;
      act_in      = act_ff;
      s_port_in   = s_port_ff;
      s_w12_in    = s_w12_ff;
      delta_in    = delta_ff;
      csum_sum_in = csum_sum_ff;
      if (accept) begin
         line_in = patched;
         if (req.in_last) begin
            cnt_in   = '0;
            off_in   = '0;
            flags_in = '0;
         end else begin
            cnt_in   = flush_cnt;
            off_in   = (off_ff == '1) ? off_ff : off_ff + 1'b1;
            flags_in = flags_next;
         end
         if (off_ff == tptr_pkg::OFF_IHL) begin
            tcp_base_in = tptr_pkg::ETH_HDR_LEN + {1'b0, req.in_byte[3:0], 2'b00};
         end
         case (rel)
            tptr_pkg::REL_PORT_HI: port_in[15:8] = req.in_byte;
            tptr_pkg::REL_PORT_LO: port_in[7:0]  = req.in_byte;
            tptr_pkg::REL_W12_HI:  w12_in[15:8]  = req.in_byte;
            tptr_pkg::REL_W12_LO:  w12_in[7:0]   = req.in_byte;
            tptr_pkg::REL_PREP: begin
               act_in      = act;
               new_port_in = np;
               new_w12_in  = nw;
               s_port_in   = {1'b0, ~port_ff} + {1'b0, np};
               s_w12_in    = {1'b0, ~w12_ff} + {1'b0, nw};
            end
            tptr_pkg::REL_FOLD:    delta_in = 17'(sum18[15:0]) + 17'(sum18[17:16]);
            tptr_pkg::REL_CSUM_HI: csum_in[15:8] = req.in_byte;
            tptr_pkg::REL_CSUM_LO: csum_in[7:0]  = req.in_byte;
            tptr_pkg::REL_CSUM_AD: csum_sum_in = {2'b00, ~csum_ff} + {1'b0, delta_ff};
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         off_ff      <= '0;
         flags_ff    <= '0;
         tcp_base_ff <= '0;
         act_ff      <= tptr_pkg::ACT_NONE;
      end else begin
         cnt_ff      <= cnt_in;
         off_ff      <= off_in;
         flags_ff    <= flags_in;
         tcp_base_ff <= tcp_base_in;
         act_ff      <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff     <= line_in;
      port_ff     <= port_in;
      w12_ff      <= w12_in;
      csum_ff     <= csum_in;
      new_port_ff <= new_port_in;
      new_w12_ff  <= new_w12_in;
      s_port_ff   <= s_port_in;
      s_w12_ff    <= s_w12_in;
      delta_ff    <= delta_in;
      csum_sum_ff <= csum_sum_in;
   end

endmodule

FILE: rtl/core/tptr_queue.sv
// tptr_queue: short FIFO of words pushed out of the delay line while a
// frame streams. Depends on tptr_pkg.

module tptr_queue #(
   parameter int DEPTH = tptr_pkg::QUEUE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  tptr_pkg::push_type  qpush,
   input  logic                pop,
   output tptr_pkg::qhead_type qhead,
   output logic                full
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [tptr_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [AW-1:0]               wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]               count_ff, count_in;

   always_comb begin
      qhead.avail = (count_ff != '0);
      qhead.data  = mem_ff[rd_ptr_ff];
      full        = (count_ff == NW'(DEPTH));
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      if (qpush.push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (qpush.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !qpush.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (qpush.push) begin
         mem_ff[wr_ptr_ff] <= qpush.data;
      end
   end

endmodule

FILE: rtl/core/tptr_back.sv
// tptr_back: drain bank for the held words of a finished frame and the
// registered output stage. Depends on tptr_pkg and tptr_ifs.

module tptr_back #(
   parameter int HOLD = tptr_pkg::HOLD_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tptr_pkg::qhead_type                   qhead,
   input  tptr_pkg::flush_type                   flush,
   input  logic [HOLD-1:0][tptr_pkg::BYTE_W-1:0] flush_bytes,
   input  logic [$clog2(HOLD+1)-1:0]             flush_cnt,
   output logic                                  pop,
   output logic                                  drain_busy,
   tptr_rsp_if.source                            rsp
);

   localparam int CW = $clog2(HOLD + 1);
   localparam int IW = $clog2(HOLD);

   logic [HOLD-1:0][7:0] drain_ff, drain_in;
   logic [CW-1:0]        dcnt_ff, dcnt_in;
   logic [1:0]           dverdict_ff, dverdict_in;
   logic [IW-1:0]        rd_idx;
   logic                 out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic [1:0]           out_verdict_ff, out_verdict_in;
   logic                 take, from_d;

   always_comb begin
      drain_busy = (dcnt_ff != '0);
      rd_idx     = IW'(CW'(HOLD) - dcnt_ff);
      take       = !out_valid_ff || rsp.ready;
      // queued words are older than anything in the drain bank
      pop        = take && qhead.avail;
      from_d     = take && !qhead.avail && drain_busy;

      drain_in    = drain_ff;
      dcnt_in     = dcnt_ff;
      dverdict_in = dverdict_ff;
      if (flush.load) begin
         drain_in    = flush_bytes;
         dcnt_in     = flush_cnt;
         dverdict_in = flush.verdict;
      end else if (from_d) begin
         dcnt_in = dcnt_ff - 1'b1;
      end

      out_valid_in   = out_valid_ff && !rsp.ready;
      out_byte_in    = out_byte_ff;
      out_last_in    = out_last_ff;
      out_verdict_in = out_verdict_ff;
      if (pop) begin
         out_valid_in   = 1'b1;
         out_byte_in    = qhead.data;
         out_last_in    = 1'b0;
         out_verdict_in = tptr_pkg::VERDICT_PASS;
      end else if (from_d) begin
         out_valid_in   = 1'b1;
         out_byte_in    = drain_ff[rd_idx];
         out_last_in    = (dcnt_ff == CW'(1));
         out_verdict_in = (dcnt_ff == CW'(1)) ? dverdict_ff : tptr_pkg::VERDICT_PASS;
      end

      rsp.valid    = out_valid_ff;
      rsp.out_byte = out_byte_ff;
      rsp.out_last = out_last_ff;
      rsp.verdict  = out_verdict_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         dcnt_ff      <= dcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drain_ff       <= drain_in;
      dverdict_ff    <= dverdict_in;
      out_byte_ff    <= out_byte_in;
      out_last_ff    <= out_last_in;
      out_verdict_ff <= out_verdict_in;
   end

endmodule

FILE: rtl/core/tcp_port_tag_rewriter.sv
// tcp_port_tag_rewriter: top level; register file, front parser, overflow
// queue and drain/output stage. Depends on tptr_pkg, tptr_ifs and submodules.
//
//   channel   dir  handshake     word
//   req_chan  in   valid/ready   in_byte[7:0], in_last
//   rsp_chan  out  valid/ready   out_byte[7:0], out_last, verdict[1:0]
//   csr_chan  in   valid/ready   reg_index[1:0], wdata[15:0]  (ready always high)
//
// One frame word is taken per cycle while req_chan does not stall, and one
// result word leaves per cycle while rsp_chan is ready. A word sits in the
// HOLD-deep delay line until HOLD newer words arrive or its frame ends. A frame
// end copies the delay line into the drain bank, which empties, as rsp_chan
// allows, behind the overflow queue; req_chan stalls only when the delay line
// is full and that bank is not empty or the queue is full, or when a frame ends
// before that bank is empty. Reset is synchronous; there is no clearing pass.

module tcp_port_tag_rewriter #(
   parameter int HOLD  = tptr_pkg::HOLD_DEFAULT,
   parameter int QUEUE = tptr_pkg::QUEUE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tptr_req_if.sink   req_chan,
   tptr_rsp_if.source rsp_chan,
   tptr_csr_if.sink   csr_chan
);

   localparam int CW = $clog2(HOLD + 1);

   tptr_pkg::cfg_type    cfg_ff, cfg_in;
   tptr_pkg::stat_type   stat;
   tptr_pkg::push_type   qpush;
   tptr_pkg::qhead_type  qhead;
   tptr_pkg::flush_type  flush;
   logic [HOLD-1:0][7:0] flush_bytes;
   logic [CW-1:0]        flush_cnt;
   logic                 pop, drain_busy, queue_full;

   // Register writes: always taken, one register a word
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            tptr_pkg::CSR_MODE_POP:     cfg_in.mode_pop     = csr_chan.wdata[0];
            tptr_pkg::CSR_FLOW_TAG:     cfg_in.flow_tag     = csr_chan.wdata[3:0];
            tptr_pkg::CSR_SERVICE_PORT: cfg_in.service_port = csr_chan.wdata;
            tptr_pkg::CSR_TUNNEL_PORT:  cfg_in.tunnel_port  = csr_chan.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_pop     <= tptr_pkg::MODE_POP_RST;
         cfg_ff.flow_tag     <= tptr_pkg::FLOW_TAG_RST;
         cfg_ff.service_port <= tptr_pkg::SERVICE_PORT_RST;
         cfg_ff.tunnel_port  <= tptr_pkg::TUNNEL_PORT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Status seen by the front: hold off overflow and frame ends while busy
   assign stat.drain_busy = drain_busy;
   assign stat.queue_full = queue_full;

   tptr_front #(.HOLD(HOLD)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .stat        (stat),
      .req         (req_chan),
      .qpush       (qpush),
      .flush       (flush),
      .flush_bytes (flush_bytes),
      .flush_cnt   (flush_cnt)
   );

   tptr_queue #(.DEPTH(QUEUE)) u_queue (
      .clock (clock),
      .reset (reset),
      .qpush (qpush),
      .pop   (pop),
      .qhead (qhead),
      .full  (queue_full)
   );

   tptr_back #(.HOLD(HOLD)) u_back (
      .clock       (clock),
      .reset       (reset),
      .qhead       (qhead),
      .flush       (flush),
      .flush_bytes (flush_bytes),
      .flush_cnt   (flush_cnt),
      .pop         (pop),
      .drain_busy  (drain_busy),
      .rsp         (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // The drain bank is loaded only when it has emptied
   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      flush.load |-> !stat.drain_busy)
      else $error("drain bank loaded while still draining");

   // The overflow queue is never pushed while full
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      qpush.push |-> !stat.queue_full)
      else $error("overflow queue pushed while full");

   // A verdict other than pass comes only with the final word of a frame
   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.out_last |-> rsp_chan.verdict == tptr_pkg::VERDICT_PASS)
      else $error("verdict on a word that is not the last");
`endif

endmodule

FILE: sim/tb_tcp_port_tag_rewriter.sv
// tb_tcp_port_tag_rewriter: self-checking bench that streams Ethernet frames through
// the TCP port tag rewriter and checks every result word against its own model.
// Depends on tptr_pkg, the tptr_ifs channel interfaces and tcp_port_tag_rewriter.

module tb_tcp_port_tag_rewriter;

   localparam int     DEPTH          = tptr_pkg::HOLD_DEFAULT;
   localparam int     SETTLE_CYCLES  = tptr_pkg::HOLD_DEFAULT + tptr_pkg::QUEUE_DEFAULT + 16;
   localparam int     HOLDOFF_CYCLES = 300;
   localparam longint CYCLE_LIMIT    = 100000;
   localparam int     BW             = tptr_pkg::BYTE_W;
   localparam int     VW             = tptr_pkg::VERDICT_W;

   localparam logic [15:0] ETYPE_IPV4 = {tptr_pkg::ETYPE_IPV4_HI, tptr_pkg::ETYPE_IPV4_LO};

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RARE, STALL_PERIODIC} stall_mode_type;

   typedef struct packed {
      logic [BW-1:0] data;
      logic          last;
      logic [VW-1:0] verdict;
   } out_word_type;

   // Recipe for one frame: header fields of interest, payload size and an
   // optional truncation length (zero keeps the whole frame)
   typedef struct {
      bit [15:0] etype;
      bit [7:0]  ver_ihl;
      bit [7:0]  proto;
      bit [15:0] dport;
      bit [3:0]  tag;
      bit [15:0] csum;
      int        payload;
      int        cap;
   } frame_spec_type;

   // Tracks the delay line, the header parse and the rewrite decision of the
   // block, and holds the words it must emit, oldest first.
   class rewrite_scoreboard;
      bit                          mode_pop;
      bit [tptr_pkg::TAG_W-1:0]    flow_tag;
      bit [tptr_pkg::PORT_W-1:0]   service_port;
      bit [tptr_pkg::PORT_W-1:0]   tunnel_port;
      bit [BW-1:0]                 line_bytes[$];
      bit [15:0]                   offset;
      int                          ip_hdr_len;
      bit                          seen_ipv4, ihl_ok, is_tcp, rewrote, drop;
      out_word_type                pending_words[$];
      int                          mismatches;

      function new();
         mode_pop     = tptr_pkg::MODE_POP_RST;
         flow_tag     = tptr_pkg::FLOW_TAG_RST;
         service_port = tptr_pkg::SERVICE_PORT_RST;
         tunnel_port  = tptr_pkg::TUNNEL_PORT_RST;
         mismatches   = 0;
         end_frame();
      endfunction

      function void end_frame();
         line_bytes.delete();
         offset     = 0;
         ip_hdr_len = 0;
         seen_ipv4  = 0;
         ihl_ok     = 0;
         is_tcp     = 0;
         rewrote    = 0;
         drop       = 0;
      endfunction

      function void set_register(logic [tptr_pkg::CSR_IDX_W-1:0] idx,
                                 logic [tptr_pkg::CSR_DAT_W-1:0] value);
         case (idx)
            tptr_pkg::CSR_MODE_POP:     mode_pop     = value[0];
            tptr_pkg::CSR_FLOW_TAG:     flow_tag     = value[tptr_pkg::TAG_W-1:0];
            tptr_pkg::CSR_SERVICE_PORT: service_port = value;
            tptr_pkg::CSR_TUNNEL_PORT:  tunnel_port  = value;
            default: ;
         endcase
      endfunction

      // Position in the delay line of TCP header byte k, with the newest held
      // word being the last header byte; -1 when it has already left
      function int slot_of(int k);
         int back;
         int idx;
         back = tptr_pkg::TCP_LAST - k;
         if (line_bytes.size() == 0 || back > line_bytes.size() - 1)
            return -1;
         idx = line_bytes.size() - 1 - back;
         return (idx < DEPTH) ? idx : -1;
      endfunction

      function bit [15:0] header_word(int k);
         int hi;
         int lo;
         hi = slot_of(k);
         lo = slot_of(k + 1);
         if (hi < 0 || lo < 0)
            return 16'h0000;
         return {line_bytes[hi], line_bytes[lo]};
      endfunction

      function void patch_word(int k, bit [15:0] v);
         int hi;
         int lo;
         hi = slot_of(k);
         lo = slot_of(k + 1);
         if (hi < 0 || lo < 0)
            return;
         line_bytes[hi] = v[15:8];
         line_bytes[lo] = v[7:0];
      endfunction

      function bit [15:0] fold16(bit [31:0] s);
         s = s[15:0] + s[31:16];
         s = s[15:0] + s[31:16];
         return s[15:0];
      endfunction

      // Decide on the frame once its TCP header is complete; patch port,
      // reserved nibble and checksum (one's complement update over both words)
      function void apply_rewrite();
         bit [15:0] port, w12, new_port, new_w12;
         bit [15:0] inv_port, inv_w12, inv_csum;
         bit [3:0]  tag;
         bit [31:0] sum;
         bit [16:0] delta;
         port = header_word(tptr_pkg::REL_PORT_HI);
         w12  = header_word(tptr_pkg::REL_W12_HI);
         tag  = w12[11:8];
         if (!mode_pop) begin
            if (port != service_port)
               return;
            new_port = tunnel_port;
            new_w12  = {w12[15:12], flow_tag, w12[7:0]};
         end else begin
            if (port != tunnel_port || tag == 4'h0)
               return;
            if (tag != flow_tag) begin
               drop = 1;
               return;
            end
            new_port = service_port;
            new_w12  = w12;
         end
         inv_port = ~port;
         inv_w12  = ~w12;
         sum      = inv_port + new_port + inv_w12 + new_w12;
         delta    = sum[15:0] + sum[31:16];
         inv_csum = ~header_word(tptr_pkg::REL_CSUM_HI);
         patch_word(tptr_pkg::REL_PORT_HI, new_port);
         patch_word(tptr_pkg::REL_W12_HI, new_w12);
         patch_word(tptr_pkg::REL_CSUM_HI, ~fold16(inv_csum + delta));
         rewrote = 1;
      endfunction

      function void note_word(bit [BW-1:0] b, bit last);
         bit [15:0]     cur;
         out_word_type  w;
         logic [VW-1:0] verdict;
         cur = offset;
         if (cur == tptr_pkg::OFF_ETYPE_LO && line_bytes.size() > 0 &&
             line_bytes.size() <= DEPTH && line_bytes[$] == tptr_pkg::ETYPE_IPV4_HI &&
             b == tptr_pkg::ETYPE_IPV4_LO)
            seen_ipv4 = 1;
         if (cur == tptr_pkg::OFF_IHL && seen_ipv4 && b[3:0] >= tptr_pkg::IHL_MIN) begin
            ihl_ok     = 1;
            ip_hdr_len = b[3:0] * 4;
         end
         if (cur == tptr_pkg::OFF_PROTO && ihl_ok && b == tptr_pkg::PROTO_TCP)
            is_tcp = 1;
         if (line_bytes.size() >= DEPTH) begin
            w.data    = line_bytes.pop_front();
            w.last    = 1'b0;
            w.verdict = tptr_pkg::VERDICT_PASS;
            pending_words.push_back(w);
         end
         line_bytes.push_back(b);
         if (is_tcp && cur == tptr_pkg::ETH_HDR_LEN + ip_hdr_len + tptr_pkg::TCP_LAST)
            apply_rewrite();
         if (offset != 16'hFFFF)
            offset++;
         if (last) begin
            verdict = drop    ? tptr_pkg::VERDICT_DROP :
                      rewrote ? tptr_pkg::VERDICT_REWRITE : tptr_pkg::VERDICT_PASS;
            foreach (line_bytes[i]) begin
               w.data    = line_bytes[i];
               w.last    = (i == line_bytes.size() - 1);
               w.verdict = w.last ? verdict : tptr_pkg::VERDICT_PASS;
               pending_words.push_back(w);
            end
            end_frame();
         end
      endfunction

      function void check_word(logic [BW-1:0] data, logic last, logic [VW-1:0] verdict);
         out_word_type want;
         if (pending_words.size() == 0) begin
            $display("%0t: result word with nothing expected: byte %02h last %0b verdict %0d",
                     $time, data, last, verdict);
            mismatches++;
            return;
         end
         want = pending_words.pop_front();
         if (data !== want.data || last !== want.last || verdict !== want.verdict) begin
            $display("%0t: result word mismatch: expected byte %02h last %0b verdict %0d, %s",
                     $time, want.data, want.last, want.verdict, "see actual below");
            $display("%0t:    actual byte %02h last %0b verdict %0d",
                     $time, data, last, verdict);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tptr_req_if req_bus();
   tptr_rsp_if rsp_bus();
   tptr_csr_if csr_bus();

   rewrite_scoreboard board;

   int     burst_left    = 0;
   bit     gaps_on       = 1'b1;
   int     holdoff_asks  = 0;
   int     holdoff_done  = 0;
   longint cycle_count   = 0;

   tcp_port_tag_rewriter DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   // Sample both channels at the rising edge; results are checked before the
   // word accepted at the same edge is noted, though the latency keeps them apart
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_word(rsp_bus.out_byte, rsp_bus.out_last, rsp_bus.verdict);
         if (req_bus.valid && req_bus.ready)
            board.note_word(req_bus.in_byte, req_bus.in_last);
      end
   end

   // Guard against a hang anywhere in the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tcp_port_tag_rewriter test failed");
         $finish;
      end
   end

   // Receiver: switch at random between stall patterns, and hold off
   // completely whenever the stimulus asks for it
   initial begin : receiver
      stall_mode_type mode;
      int             mode_left;
      int             holdoff_left;
      mode         = STALL_NONE;
      mode_left    = 0;
      holdoff_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_left == 0 && holdoff_done != holdoff_asks) begin
            holdoff_done++;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(40, 400);
            end
            mode_left--;
            case (mode)
               STALL_NONE:   rsp_bus.ready <= 1'b1;
               STALL_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
               STALL_RARE:   rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               default:      rsp_bus.ready <= ((mode_left % 5) < 3);
            endcase
         end
      end
   end

   // Offer one frame word; open a new burst, after a random gap, when the
   // current one is used up. Valid stays high between words of a burst.
   task automatic push_word(bit [BW-1:0] b, bit last);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Build the frame bytes from a recipe and stream them, marking the last
   task automatic send_frame(frame_spec_type s);
      bit [BW-1:0] bytes[$];
      bit [BW-1:0] tcp[20];
      int          ip_len;
      repeat (12) bytes.push_back(8'($urandom));
      bytes.push_back(s.etype[15:8]);
      bytes.push_back(s.etype[7:0]);
      bytes.push_back(s.ver_ihl);
      ip_len = (s.ver_ihl[3:0] >= tptr_pkg::IHL_MIN) ? s.ver_ihl[3:0] * 4 : 20;
      // fill the rest of the IP header, protocol at its fixed offset
      repeat (ip_len - 1)
         bytes.push_back((bytes.size() == tptr_pkg::OFF_PROTO) ? s.proto : 8'($urandom));
      foreach (tcp[k]) tcp[k] = 8'($urandom);
      tcp[tptr_pkg::REL_PORT_HI]     = s.dport[15:8];
      tcp[tptr_pkg::REL_PORT_LO]     = s.dport[7:0];
      tcp[tptr_pkg::REL_W12_HI][3:0] = s.tag;
      tcp[tptr_pkg::REL_CSUM_HI]     = s.csum[15:8];
      tcp[tptr_pkg::REL_CSUM_LO]     = s.csum[7:0];
      foreach (tcp[k]) bytes.push_back(tcp[k]);
      repeat (s.payload) bytes.push_back(8'($urandom));
      // truncate where asked, to cut the frame inside its headers
      while (s.cap > 0 && bytes.size() > s.cap)
         void'(bytes.pop_back());
      foreach (bytes[i])
         push_word(bytes[i], i == bytes.size() - 1);
   endtask

   function automatic frame_spec_type make_spec(bit [15:0] dport, bit [3:0] tag,
                                                bit [7:0] ver_ihl = 8'h45,
                                                bit [15:0] etype = ETYPE_IPV4,
                                                bit [7:0] proto = tptr_pkg::PROTO_TCP,
                                                int payload = 6, int cap = 0);
      frame_spec_type s;
      s.etype   = etype;
      s.ver_ihl = ver_ihl;
      s.proto   = proto;
      s.dport   = dport;
      s.tag     = tag;
      s.csum    = 16'($urandom);
      s.payload = payload;
      s.cap     = cap;
      return s;
   endfunction

   task automatic write_register(logic [tptr_pkg::CSR_IDX_W-1:0] idx,
                                 logic [tptr_pkg::CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= value;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_register(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(bit mode, bit [3:0] tag, bit [15:0] svc, bit [15:0] tun);
      write_register(tptr_pkg::CSR_MODE_POP, 16'(mode));
      write_register(tptr_pkg::CSR_FLOW_TAG, 16'(tag));
      write_register(tptr_pkg::CSR_SERVICE_PORT, svc);
      write_register(tptr_pkg::CSR_TUNNEL_PORT, tun);
   endtask

   // Drop valid, wait for every expected word, then give the output stage
   // time to empty before anything else happens
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      frame_spec_type s;
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.in_byte   = '0;
      req_bus.in_last   = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = '0;
      csr_bus.wdata     = '0;
      board = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames on the reset settings: push mode, tag 1, 8080 to 80.
      // Starve the output through the first one while the sender keeps going.
      holdoff_asks++;
      send_frame(make_spec(tptr_pkg::SERVICE_PORT_RST, 4'h7, 8'h46, ETYPE_IPV4,
                           tptr_pkg::PROTO_TCP, 0));
      // IHL below the minimum stops the parse
      send_frame(make_spec(tptr_pkg::SERVICE_PORT_RST, 4'h3, 8'h44, ETYPE_IPV4,
                           tptr_pkg::PROTO_TCP, 0, 24));
      // end one byte short of the TCP header
      send_frame(make_spec(tptr_pkg::SERVICE_PORT_RST, 4'h3, 8'h45, ETYPE_IPV4,
                           tptr_pkg::PROTO_TCP, 0,
                           tptr_pkg::ETH_HDR_LEN + 20 + tptr_pkg::TCP_LAST));
      // frames around the delay line depth, back to back
      gaps_on = 1'b0;
      send_frame(make_spec(tptr_pkg::SERVICE_PORT_RST, 4'h0, 8'h45, ETYPE_IPV4,
                           tptr_pkg::PROTO_TCP, 0, 1));
      send_frame(make_spec(tptr_pkg::SERVICE_PORT_RST, 4'h0, 8'h45, ETYPE_IPV4,
                           tptr_pkg::PROTO_TCP, 0, DEPTH));
      send_frame(make_spec(tptr_pkg::SERVICE_PORT_RST, 4'h0, 8'h45, ETYPE_IPV4,
                           tptr_pkg::PROTO_TCP, 0, DEPTH + 1));
      gaps_on = 1'b1;

      // Pop mode with extreme ports and tag: restore, drop, tag zero
      settle();
      configure(1'b1, 4'hF, 16'hFFFF, 16'h0000);
      s = make_spec(16'h0000, 4'hF, 8'h45, ETYPE_IPV4, tptr_pkg::PROTO_TCP, 0);
      s.csum = 16'h0000;
      send_frame(s);
      send_frame(make_spec(16'h0000, 4'h3, 8'h45, ETYPE_IPV4, tptr_pkg::PROTO_TCP, 0));
      send_frame(make_spec(16'h0000, 4'h0, 8'h45, ETYPE_IPV4, tptr_pkg::PROTO_TCP, 0));

      settle();
      if (board.mismatches == 0 && board.pending_words.size() == 0)
         $display("tcp_port_tag_rewriter test passed");
      else
         $display("tcp_port_tag_rewriter test failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/tptr_pkg.sv
rtl/core/tptr_ifs.sv
rtl/core/tptr_front.sv
rtl/core/tptr_queue.sv
rtl/core/tptr_back.sv
rtl/core/tcp_port_tag_rewriter.sv
sim/tb_tcp_port_tag_rewriter.sv
